// ----- rtl/core/qata_pkg.sv -----
package qata_pkg;

  // Fixed field widths of the transaction payloads
  localparam int TS_W   = 48;
  localparam int CNT_W  = 32;
  localparam int TRIG_W = 32;

  // Default width of internal time arithmetic (legal range 32..64)
  localparam int TIME_BITS_DEF = 48;

  // One day in milliseconds, period start fallback
  localparam longint unsigned DAY_MS = 64'd86400000;

  typedef enum logic [1:0] {
    MODE_SAMPLE     = 2'd0,
    MODE_INCIDENT   = 2'd1,
    MODE_SNAPSHOT   = 2'd2,
    MODE_SNAP_RESET = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [TS_W-1:0]   timestamp_ms;
    logic              signal_above;
    logic              interference_on;
  } in_item_t;

  typedef struct packed {
    logic [TS_W-1:0]   period_start_ms;
    logic [TS_W-1:0]   period_end_ms;
    logic [CNT_W-1:0]  incidents;
    logic [TS_W-1:0]   signal_active_ms;
    logic [TS_W-1:0]   interference_active_ms;
  } out_item_t;

  // Per-transaction control from the top level to each channel
  typedef struct packed {
    logic fire_sample;   // state sample is committed this cycle
    logic fire_restart;  // snapshot with period restart is committed
    logic lu_valid;      // last update time is valid
    logic min_zero;      // minimum trigger time is zero
  } chan_ctl_t;

endpackage

// ----- rtl/core/qualified_active_time_accumulator.sv -----
// Qualified active time accumulator. Takes one transaction per clock: state
// samples and incidents update the period state, snapshots return one result
// with the period start, incident count and both qualified active times,
// projected to the snapshot time. A snapshot's result is presented with
// out_valid, at the earliest, after the input register and then the result
// register; the state update for a transaction completes as it leaves the
// input register, so back-to-back transactions sustain one per cycle unless
// the input stalls. A snapshot holds in the input register only while the
// result register is full and out_stall is high.
// min_trigger_ms is written through cfg_valid/cfg_data (cfg_ready is always
// high) and should change only while the block is idle.
module qualified_active_time_accumulator #(
  parameter int TIME_BITS = qata_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  qata_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output qata_pkg::out_item_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [qata_pkg::TRIG_W-1:0]  cfg_data
);

  localparam logic [TIME_BITS-1:0] DAY = TIME_BITS'(qata_pkg::DAY_MS);

  logic                          in_v_r, in_v_nxt;
  qata_pkg::in_item_t            in_r;
  logic                          out_v_r, out_v_nxt;
  qata_pkg::out_item_t           out_r;

  logic [qata_pkg::TRIG_W-1:0]   min_r;
  logic [TIME_BITS-1:0]          ps_r, ps_nxt;
  logic                          psv_r, psv_nxt;
  logic [TIME_BITS-1:0]          lu_r, lu_nxt;
  logic                          luv_r, luv_nxt;
  logic [qata_pkg::CNT_W-1:0]    inc_r, inc_nxt;

  logic                          produces, fire, accept;
  logic [TIME_BITS-1:0]          t;
  logic [TIME_BITS-1:0]          ps_rep;
  qata_pkg::chan_ctl_t           ctl;
  logic [TIME_BITS-1:0]          proj_sig, proj_intf;

  // Handshake and transaction flow
  always_comb begin
    produces  = (in_r.mode == qata_pkg::MODE_SNAPSHOT) ||
                (in_r.mode == qata_pkg::MODE_SNAP_RESET);
    fire      = in_v_r && (!produces || !out_v_r || !out_stall);
    in_stall  = in_v_r && !fire;
    accept    = in_valid && !in_stall;
    in_v_nxt  = accept || (in_v_r && !fire);
    out_v_nxt = (fire && produces) || (out_v_r && out_stall);
    cfg_ready = 1'b1;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign t         = TIME_BITS'(in_r.timestamp_ms);

  // Channel control
  always_comb begin
    ctl.fire_sample  = fire && (in_r.mode == qata_pkg::MODE_SAMPLE);
    ctl.fire_restart = fire && (in_r.mode == qata_pkg::MODE_SNAP_RESET);
    ctl.lu_valid     = luv_r;
    ctl.min_zero     = (min_r == '0);
  end

  qata_chan #(.TIME_BITS(TIME_BITS)) u_chan_sig (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .t           (t),
    .last_update (lu_r),
    .min_trig    (min_r),
    .flag        (in_r.signal_above),
    .proj        (proj_sig)
  );

  qata_chan #(.TIME_BITS(TIME_BITS)) u_chan_intf (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .t           (t),
    .last_update (lu_r),
    .min_trig    (min_r),
    .flag        (in_r.interference_on),
    .proj        (proj_intf)
  );

  // Reported period start, one day back when none is recorded (zero before one day)
  always_comb begin
    if (psv_r) begin
      ps_rep = ps_r;
    end else if (t >= DAY) begin
      ps_rep = t - DAY;
    end else begin
      ps_rep = '0;
    end
  end

  // Period state update
  always_comb begin
    ps_nxt  = ps_r;
    psv_nxt = psv_r;
    lu_nxt  = lu_r;
    luv_nxt = luv_r;
    inc_nxt = inc_r;
    if (fire) begin
      case (in_r.mode)
        qata_pkg::MODE_SAMPLE: begin
          if (!psv_r) begin
            ps_nxt  = t;
            psv_nxt = 1'b1;
          end
          lu_nxt  = t;
          luv_nxt = 1'b1;
        end
        qata_pkg::MODE_INCIDENT: begin
          if (!psv_r) begin
            ps_nxt  = t;
            psv_nxt = 1'b1;
          end
          if (inc_r != {qata_pkg::CNT_W{1'b1}}) begin
            inc_nxt = inc_r + qata_pkg::CNT_W'(1);
          end
        end
        qata_pkg::MODE_SNAP_RESET: begin
          ps_nxt  = t;
          psv_nxt = 1'b1;
          inc_nxt = '0;
          lu_nxt  = t;
          luv_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      min_r   <= '0;
      ps_r    <= '0;
      psv_r   <= 1'b0;
      lu_r    <= '0;
      luv_r   <= 1'b0;
      inc_r   <= '0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_valid && cfg_ready) begin
        min_r <= cfg_data;
      end
      ps_r    <= ps_nxt;
      psv_r   <= psv_nxt;
      lu_r    <= lu_nxt;
      luv_r   <= luv_nxt;
      inc_r   <= inc_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    if (fire && produces) begin
      out_r.period_start_ms        <= qata_pkg::TS_W'(ps_rep);
      out_r.period_end_ms          <= qata_pkg::TS_W'(t);
      out_r.incidents              <= inc_r;
      out_r.signal_active_ms       <= qata_pkg::TS_W'(proj_sig);
      out_r.interference_active_ms <= qata_pkg::TS_W'(proj_intf);
    end
  end

  // Checks
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_v_r && produces && out_v_r)
    else $error("input stalled without a pending snapshot");

  a_snap_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && produces |=> out_v_r)
    else $error("snapshot transaction produced no result");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire_restart |=> inc_r == '0 && psv_r && luv_r)
    else $error("period restart did not clear the period state");

  a_sample_time: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire_sample |=> luv_r && lu_r == $past(t))
    else $error("state sample did not record its time");

  a_no_inc_without_period: assert property (@(posedge clk) disable iff (!rst_n)
    !psv_r |-> inc_r == '0)
    else $error("incidents counted with no period started");

endmodule

// ----- rtl/core/qata_chan.sv -----
// One qualified-time channel: run tracking, total and snapshot projection
module qata_chan #(
  parameter int TIME_BITS = qata_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  qata_pkg::chan_ctl_t           ctl,
  input  logic [TIME_BITS-1:0]          t,
  input  logic [TIME_BITS-1:0]          last_update,
  input  logic [qata_pkg::TRIG_W-1:0]   min_trig,
  input  logic                          flag,
  output logic [TIME_BITS-1:0]          proj
);

  logic [TIME_BITS-1:0] tot_r, tot_nxt;
  logic [TIME_BITS-1:0] rs_r, rs_nxt;
  logic                 rsv_r, rsv_nxt;
  logic                 conf_r, conf_nxt;
  logic                 lf_r, lf_nxt;

  logic [TIME_BITS-1:0] min_ext;
  logic [TIME_BITS-1:0] el, rs_eff, d_s, d_p;
  logic [TIME_BITS-1:0] sum_el, sum_s, sum_p;
  logic                 gate, long_s, long_p, fast;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                  input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  // Elapsed times and qualification checks
  always_comb begin
    min_ext = TIME_BITS'(min_trig);
    el      = t - last_update;
    gate    = ctl.lu_valid && lf_r && (t > last_update);
    fast    = ctl.min_zero || conf_r;
    // a run not yet started is taken to begin at the last update
    rs_eff  = rsv_r ? rs_r : last_update;
    d_s     = t - rs_eff;
    d_p     = t - rs_r;
    long_s  = (t >= rs_eff) && (d_s >= min_ext);
    long_p  = rsv_r && (t >= rs_r) && (d_p >= min_ext);
    sum_el  = sat_add(tot_r, el);
    sum_s   = sat_add(tot_r, d_s);
    sum_p   = sat_add(tot_r, d_p);
  end

  // Snapshot projection of the open run
  always_comb begin
    if (!gate) begin
      proj = tot_r;
    end else if (fast) begin
      proj = sum_el;
    end else if (long_p) begin
      proj = sum_p;
    end else begin
      proj = tot_r;
    end
  end

  // Next state
  always_comb begin
    tot_nxt  = tot_r;
    rs_nxt   = rs_r;
    rsv_nxt  = rsv_r;
    conf_nxt = conf_r;
    lf_nxt   = lf_r;
    if (ctl.fire_sample) begin
      if (gate) begin
        if (fast) begin
          tot_nxt  = sum_el;
          conf_nxt = 1'b1;
        end else begin
          rs_nxt  = rs_eff;
          rsv_nxt = 1'b1;
          if (long_s) begin
            tot_nxt  = sum_s;
            conf_nxt = 1'b1;
          end
        end
      end
      if (flag) begin
        if (!lf_r) begin
          rs_nxt   = t;
          rsv_nxt  = 1'b1;
          conf_nxt = ctl.min_zero;
        end
      end else begin
        rs_nxt   = '0;
        rsv_nxt  = 1'b0;
        conf_nxt = 1'b0;
      end
      lf_nxt = flag;
    end else if (ctl.fire_restart) begin
      tot_nxt = '0;
      if (lf_r) begin
        rs_nxt   = t;
        rsv_nxt  = 1'b1;
        conf_nxt = conf_r || ctl.min_zero || long_p;
      end else begin
        rs_nxt   = '0;
        rsv_nxt  = 1'b0;
        conf_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r  <= '0;
      rs_r   <= '0;
      rsv_r  <= 1'b0;
      conf_r <= 1'b0;
      lf_r   <= 1'b0;
    end else begin
      tot_r  <= tot_nxt;
      rs_r   <= rs_nxt;
      rsv_r  <= rsv_nxt;
      conf_r <= conf_nxt;
      lf_r   <= lf_nxt;
    end
  end

endmodule
